FILE: rtl/sdpb_pkg.sv
// Package of the soft disc blend unit: register indexes, fixed widths,
// rounding constants and the tag that travels with each pixel.
// No dependencies.
package sdpb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_DISC_RADIUS  = 3'd2,
    REG_SOURCE_RED   = 3'd3,
    REG_SOURCE_GREEN = 3'd4,
    REG_SOURCE_BLUE  = 3'd5,
    REG_SOURCE_ALPHA = 3'd6
  } cfg_reg_t;

  // Squared doubled radius and the remainder of the divider.
  localparam int RW         = 26;
  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 17;
  localparam int SQW        = 35;
  localparam int FW         = 17;

  localparam logic [FW-1:0] ONE16     = 17'h10000;
  localparam logic [17:0]   THREE16   = 18'h30000;
  localparam logic [33:0]   HALF16    = 34'h8000;
  localparam logic [24:0]   RECIP_255 = 25'd16843010;

  typedef struct packed {
    logic        valid;
    logic        covered;
    logic [31:0] dest;
  } tag_t;

endpackage

FILE: rtl/soft_disc_premultiplied_blend_unit.sv
// Top level of the soft disc blend unit: the whole compositing pipeline.
// Depends on sdpb_pkg.
//
// Usage: each input beat carries a pixel position and its premultiplied ARGB
// destination word; each output beat carries the blended word and a flag that
// is set when the disc covered the pixel with nonzero alpha. Both channels use
// valid and stall. The disc is set through the write port (center, radius,
// straight color, peak alpha); the user must see that it is written only while
// no pixel is in flight, as the block itself does not enforce this. One pixel
// is accepted every cycle while the output is not stalled: the distance
// division takes one quotient bit per stage over 33 stages and the square root
// one root bit per stage over 17 stages, followed by a chain of registered
// multipliers for the falloff, the alpha and the byte blend.
// When the receiver stalls a waiting result, the whole pipeline holds and the
// input is stalled in the same cycle; nothing is lost or repeated.
// Reset, synchronous and active high, clears all valid bits and all disc
// registers; a zero radius passes every pixel through unchanged.
module soft_disc_premultiplied_blend_unit #(
  parameter int COORD_FRAC_BITS  = 4,
  parameter int PIXEL_COORD_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sdpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sdpb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [PIXEL_COORD_BITS-1:0]          pixel_x,
  input  logic [PIXEL_COORD_BITS-1:0]          pixel_y,
  input  logic [31:0]                          dest_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          result_pixel,
  output logic                                 pixel_written
);
  import sdpb_pkg::*;

  localparam int POS_W = PIXEL_COORD_BITS + COORD_FRAC_BITS + 1;
  localparam int DW    = ((POS_W > 17) ? POS_W : 17) + 2;
  localparam int AW    = DW - 1;
  localparam int D2W   = 2 * AW + 1;

  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [11:0]        disc_radius;
  logic [7:0]         source_red;
  logic [7:0]         source_green;
  logic [7:0]         source_blue;
  logic [7:0]         source_alpha;
  logic [RW-1:0]      r2;
  logic               en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      disc_radius  <= '0;
      source_red   <= '0;
      source_green <= '0;
      source_blue  <= '0;
      source_alpha <= '0;
      r2           <= '0;
    end else begin
      r2 <= RW'({1'b0, disc_radius, 1'b0} * {1'b0, disc_radius, 1'b0});
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:     center_x     <= signed'(cfg_data);
          REG_CENTER_Y:     center_y     <= signed'(cfg_data);
          REG_DISC_RADIUS:  disc_radius  <= cfg_data[11:0];
          REG_SOURCE_RED:   source_red   <= cfg_data[7:0];
          REG_SOURCE_GREEN: source_green <= cfg_data[7:0];
          REG_SOURCE_BLUE:  source_blue  <= cfg_data[7:0];
          REG_SOURCE_ALPHA: source_alpha <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Distances along each axis in half sixteenths of a pixel.
  logic [POS_W-1:0]     pos_x, pos_y;
  logic signed [DW-1:0] dx, dy;
  logic [AW-1:0]        ax, ay;
  tag_t                 s0_tag, s1_tag, s2_tag;
  logic [2*AW-1:0]      sqx, sqy;
  logic [D2W-1:0]       d2_sum;
  logic [RW-1:0]        s2_d2;

  assign pos_x  = (POS_W'(pixel_x) << (COORD_FRAC_BITS + 1)) | (POS_W'(1) << COORD_FRAC_BITS);
  assign pos_y  = (POS_W'(pixel_y) << (COORD_FRAC_BITS + 1)) | (POS_W'(1) << COORD_FRAC_BITS);
  assign dx     = $signed(DW'(pos_x)) - DW'(signed'({center_x, 1'b0}));
  assign dy     = $signed(DW'(pos_y)) - DW'(signed'({center_y, 1'b0}));
  assign d2_sum = D2W'(sqx) + D2W'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag.valid <= 1'b0;
      s1_tag.valid <= 1'b0;
      s2_tag.valid <= 1'b0;
    end else if (en) begin
      s0_tag <= '{valid: in_valid, covered: 1'b0, dest: dest_pixel};
      ax     <= dx[DW-1] ? AW'(-dx) : AW'(dx);
      ay     <= dy[DW-1] ? AW'(-dy) : AW'(dy);
      s1_tag <= s0_tag;
      sqx    <= ax * ax;
      sqy    <= ay * ay;
      s2_tag <= '{valid: s1_tag.valid,
                  covered: (r2 != '0) && (d2_sum <= D2W'(r2)),
                  dest: s1_tag.dest};
      s2_d2  <= d2_sum[RW-1:0];
    end
  end

  // Restoring division of d2 * 2^32 by r2, one quotient bit per stage.
  tag_t                 div_tag [DIV_STEPS];
  logic [RW-1:0]        div_rem [DIV_STEPS];
  logic [DIV_STEPS-1:0] div_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tag_t                 tag_in;
    logic [RW-1:0]        rem_in;
    logic [DIV_STEPS-1:0] q_in;
    logic [RW:0]          sh;
    logic [RW:0]          diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign tag_in = s2_tag;
      assign rem_in = s2_d2;
      assign q_in   = '0;
      assign sh     = {1'b0, rem_in};
    end else begin : g_next
      assign tag_in = div_tag[k-1];
      assign rem_in = div_rem[k-1];
      assign q_in   = div_q[k-1];
      assign sh     = {rem_in, 1'b0};
    end
    assign diff = sh - {1'b0, r2};
    assign take = (sh >= {1'b0, r2});

    always_ff @(posedge clk) begin
      if (rst) begin
        div_tag[k].valid <= 1'b0;
      end else if (en) begin
        div_tag[k] <= tag_in;
        div_rem[k] <= take ? diff[RW-1:0] : sh[RW-1:0];
        div_q[k]   <= {q_in[DIV_STEPS-2:0], take};
      end
    end
  end

  // Integer square root of the quotient, one root bit per stage.
  tag_t          sq_tag  [SQRT_STEPS];
  logic [SQW-1:0] sq_rem [SQRT_STEPS];
  logic [FW-1:0] sq_root [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int I = SQRT_STEPS - 1 - j;
    tag_t           tag_in;
    logic [SQW-1:0] rem_in;
    logic [FW-1:0]  root_in;
    logic [SQW-1:0] trial;
    logic           take;

    if (j == 0) begin : g_first
      assign tag_in  = div_tag[DIV_STEPS-1];
      assign rem_in  = SQW'(div_q[DIV_STEPS-1]);
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = sq_tag[j-1];
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
    end
    assign trial = (SQW'(root_in) << (I + 1)) + (SQW'(1) << (2 * I));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_tag[j].valid <= 1'b0;
      end else if (en) begin
        sq_tag[j]  <= tag_in;
        sq_rem[j]  <= take ? (rem_in - trial) : rem_in;
        sq_root[j] <= take ? (root_in | (FW'(1) << I)) : root_in;
      end
    end
  end

  // Smoothstep, falloff, alpha and the byte blend.
  logic [FW-1:0] t;
  tag_t          ta_tag, tb_tag, tc_tag, td_tag, te_tag, tf_tag, tg_tag, th_tag;
  tag_t          ti_tag, tj_tag;
  logic [33:0]   ta_t2p;
  logic [17:0]   ta_k, tb_k;
  logic [FW-1:0] tb_t2;
  logic [34:0]   tc_sp;
  logic [19:0]   s_full;
  logic [FW-1:0] td_f;
  logic [33:0]   te_f2p;
  logic [FW-1:0] tf_f2;
  logic [24:0]   tg_ap;
  logic [49:0]   th_q;
  logic [17:0]   a_full;
  logic [FW-1:0] ti_a;
  logic [FW-1:0] inv_a;
  logic [7:0]    src_b [4];
  logic [7:0]    dst_b [4];
  logic [24:0]   tj_sp [4];
  logic [24:0]   tj_dp [4];
  logic [25:0]   mix   [4];
  logic [7:0]    mixb  [4];

  assign t      = sq_root[SQRT_STEPS-1];
  assign s_full = 20'((35'(tc_sp) + 35'(HALF16)) >> 16);
  assign a_full = 18'(th_q >> 32);
  assign inv_a  = ONE16 - ti_a;
  assign src_b[0] = 8'hFF;
  assign src_b[1] = source_red;
  assign src_b[2] = source_green;
  assign src_b[3] = source_blue;

  for (genvar b = 0; b < 4; b++) begin : g_byte
    assign dst_b[b] = ti_tag.dest[31-8*b -: 8];
    assign mix[b]   = 26'(tj_sp[b]) + 26'(tj_dp[b]) + 26'(HALF16);
    assign mixb[b]  = (mix[b][25:16] > 10'd255) ? 8'hFF : mix[b][23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ta_tag.valid <= 1'b0;
      tb_tag.valid <= 1'b0;
      tc_tag.valid <= 1'b0;
      td_tag.valid <= 1'b0;
      te_tag.valid <= 1'b0;
      tf_tag.valid <= 1'b0;
      tg_tag.valid <= 1'b0;
      th_tag.valid <= 1'b0;
      ti_tag.valid <= 1'b0;
      tj_tag.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else if (en) begin
      ta_tag <= sq_tag[SQRT_STEPS-1];
      ta_t2p <= 34'(t) * 34'(t);
      ta_k   <= THREE16 - {t, 1'b0};
      tb_tag <= ta_tag;
      tb_t2  <= FW'((ta_t2p + HALF16) >> 16);
      tb_k   <= ta_k;
      tc_tag <= tb_tag;
      tc_sp  <= 35'(tb_t2) * 35'(tb_k);
      td_tag <= tc_tag;
      td_f   <= (s_full > 20'(ONE16)) ? '0 : FW'(20'(ONE16) - s_full);
      te_tag <= td_tag;
      te_f2p <= 34'(td_f) * 34'(td_f);
      tf_tag <= te_tag;
      tf_f2  <= FW'((te_f2p + HALF16) >> 16);
      tg_tag <= tf_tag;
      tg_ap  <= 25'(source_alpha) * 25'(tf_f2) + 25'd127;
      th_tag <= tg_tag;
      th_q   <= 50'(tg_ap) * 50'(RECIP_255);
      ti_tag <= '{valid: th_tag.valid,
                  covered: th_tag.covered && (a_full != '0),
                  dest: th_tag.dest};
      ti_a   <= (a_full > 18'(ONE16)) ? ONE16 : FW'(a_full);
      tj_tag <= ti_tag;
      for (int b = 0; b < 4; b++) begin
        tj_sp[b] <= 25'(src_b[b]) * 25'(ti_a);
        tj_dp[b] <= 25'(dst_b[b]) * 25'(inv_a);
      end
      out_valid     <= tj_tag.valid;
      pixel_written <= tj_tag.covered;
      result_pixel  <= tj_tag.covered ? {mixb[0], mixb[1], mixb[2], mixb[3]} : tj_tag.dest;
    end
  end

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    div_tag[DIV_STEPS-1].valid && div_tag[DIV_STEPS-1].covered &&
    div_q[DIV_STEPS-1][DIV_STEPS-1] |-> (div_q[DIV_STEPS-1][DIV_STEPS-2:0] == '0))
    else $error("distance ratio above one");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_tag[SQRT_STEPS-1].valid && sq_tag[SQRT_STEPS-1].covered |->
    (sq_root[SQRT_STEPS-1] <= ONE16))
    else $error("square root above one");

  a_written_needs_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_written |-> (disc_radius != '0) && (source_alpha != '0))
    else $error("pixel written with an empty disc");

endmodule

FILE: dv/sdpb_checker.sv
// Checker of the soft disc blend unit: watches the write port and both channels,
// predicts each blended pixel and compares it with the output beats.
// Depends on sdpb_pkg.
`timescale 1ns / 100ps
module sdpb_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sdpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sdpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [10:0]                       pixel_x,
  input  logic [10:0]                       pixel_y,
  input  logic [31:0]                       dest_pixel,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [31:0]                       result_pixel,
  input  logic                              pixel_written,
  output int                                fail_count,
  output int                                pending
);
  import sdpb_pkg::*;

  typedef struct {
    logic [31:0] pix;
    logic        written;
  } blend_t;

  logic signed [15:0] cx, cy;
  logic [11:0]        radius;
  logic [7:0]         src_r, src_g, src_b, src_a;
  blend_t             blend_q[$];

  assign pending = blend_q.size();

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_offset(logic [10:0] p, logic signed [15:0] c);
    longint signed d;
    d = (longint'(p) <<< 5) + 16 - 2 * longint'(c);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic longint unsigned mix(longint unsigned s, longint unsigned d,
                                          longint unsigned a);
    longint unsigned v;
    v = (s * a + d * (65536 - a) + 32768) >> 16;
    return v > 255 ? 255 : v;
  endfunction

  function automatic blend_t predict_blend(logic [10:0] px, logic [10:0] py,
                                           logic [31:0] dst);
    blend_t b;
    longint unsigned d2, r2, t, t2, s, f, f2, a;
    b.pix = dst;
    b.written = 1'b0;
    if (radius == 0) return b;
    d2 = sq_offset(px, cx) + sq_offset(py, cy);
    r2 = (2 * longint'(radius)) * (2 * longint'(radius));
    if (d2 > r2) return b;
    t = root_floor((d2 << 32) / r2);
    if (t > 65536) t = 65536;
    t2 = (t * t + 32768) >> 16;
    s = (t2 * (3 * 65536 - 2 * t) + 32768) >> 16;
    if (s > 65536) s = 65536;
    f = 65536 - s;
    f2 = (f * f + 32768) >> 16;
    a = (longint'(src_a) * f2 + 127) / 255;
    if (a > 65536) a = 65536;
    if (a == 0) return b;
    b.pix = {8'(mix(255, dst[31:24], a)), 8'(mix(src_r, dst[23:16], a)),
             8'(mix(src_g, dst[15:8], a)), 8'(mix(src_b, dst[7:0], a))};
    b.written = 1'b1;
    return b;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    blend_t e;
    if (rst) begin
      cx <= '0; cy <= '0; radius <= '0;
      src_r <= '0; src_g <= '0; src_b <= '0; src_a <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:     cx <= cfg_data;
          REG_CENTER_Y:     cy <= cfg_data;
          REG_DISC_RADIUS:  radius <= cfg_data[11:0];
          REG_SOURCE_RED:   src_r <= cfg_data[7:0];
          REG_SOURCE_GREEN: src_g <= cfg_data[7:0];
          REG_SOURCE_BLUE:  src_b <= cfg_data[7:0];
          REG_SOURCE_ALPHA: src_a <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        blend_q.push_back(predict_blend(pixel_x, pixel_y, dest_pixel));
      if (out_valid && !out_stall) begin
        if (blend_q.size() == 0) begin
          report_mismatch("result beat with no pixel expected");
        end else begin
          e = blend_q.pop_front();
          if (result_pixel !== e.pix)
            report_mismatch($sformatf("result_pixel %h, expected %h", result_pixel, e.pix));
          if (pixel_written !== e.written)
            report_mismatch($sformatf("pixel_written %b, expected %b",
                                      pixel_written, e.written));
        end
      end
    end
  end
endmodule

FILE: dv/tb_soft_disc_premultiplied_blend_unit.sv
// Testbench top of the soft disc blend unit: drives disc settings and pixel
// beats with random gaps and stalls; sdpb_checker predicts and compares.
// Depends on sdpb_pkg, sdpb_checker and the unit.
`timescale 1ns / 100ps
module tb_soft_disc_premultiplied_blend_unit;
  import sdpb_pkg::*;

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_stall, out_valid, out_stall, pixel_written;
  logic [10:0] pixel_x, pixel_y;
  logic [31:0] dest_pixel, result_pixel;
  int          fail_count, pending;
  int          send_idle, recv_idle;

  soft_disc_premultiplied_blend_unit u_dut (.*);
  sdpb_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_disc(logic [15:0] x, logic [15:0] y, logic [11:0] r,
                          logic [31:0] argb);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_DISC_RADIUS, {4'd0, r});
    write_reg(REG_SOURCE_ALPHA, {8'd0, argb[31:24]});
    write_reg(REG_SOURCE_RED, {8'd0, argb[23:16]});
    write_reg(REG_SOURCE_GREEN, {8'd0, argb[15:8]});
    write_reg(REG_SOURCE_BLUE, {8'd0, argb[7:0]});
  endtask

  task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    dest_pixel <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Pixels cluster near the disc center so many land inside it.
  task automatic random_phase(int n);
    int cxp, cyp, r;
    logic [10:0] x, y;
    cxp = $urandom_range(2047);
    cyp = $urandom_range(2047);
    r = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(400);
    if ($urandom_range(7) == 0) r = 4095;
    set_disc($urandom_range(15) == 0 ? 16'($urandom()) : 16'(cxp * 16 + $urandom_range(15)),
             16'(cyp * 16 + $urandom_range(15)), r[11:0], $urandom());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) != 0) begin
        x = 11'(cxp + $signed($urandom_range(2 * (r / 16 + 2))) - (r / 16 + 2));
        y = 11'(cyp + $signed($urandom_range(2 * (r / 16 + 2))) - (r / 16 + 2));
      end else begin
        x = 11'($urandom());
        y = 11'($urandom());
      end
      send_pixel(x, y, $urandom());
    end
    drain();
  endtask

  initial begin
    rst = 1; cfg_write = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; pixel_x = '0; pixel_y = '0; dest_pixel = '0;
    out_stall = 0; send_idle = 27; recv_idle = 66;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_pixel(11'd5, 11'd5, 32'h80402010);
    drain();
    set_disc(16'h0808, 16'h0808, 12'd64, 32'hFFFF8000);
    send_pixel(11'd128, 11'd128, 32'h00000000);
    send_pixel(11'd128, 11'd128, 32'hFFFFFFFF);
    send_pixel(11'd132, 11'd128, 32'h80FF0040);
    send_pixel(11'd131, 11'd128, 32'h10203040);
    send_pixel(11'd124, 11'd128, 32'h20FFFFFF);
    send_pixel(11'd2047, 11'd2047, 32'hFFFFFFFF);
    send_pixel(11'd0, 11'd0, 32'h12345678);
    drain();
    set_disc(16'h7FFF, 16'h8000, 12'd4095, 32'h01FFFFFF);
    send_pixel(11'd2047, 11'd0, 32'hFFFFFFFF);
    send_pixel(11'd2047, 11'd2, 32'h00000000);
    send_pixel(11'd1800, 11'd100, 32'hA5A5A5A5);
    drain();
    set_disc(16'h0008, 16'h0008, 12'd8, 32'h00FF00FF);
    send_pixel(11'd0, 11'd0, 32'h55AA55AA);
    drain();
    set_disc(16'h0008, 16'h0008, 12'd4095, 32'hFF00FF00);
    send_pixel(11'd0, 11'd0, 32'h55AA55AA);
    send_pixel(11'd200, 11'd10, 32'h00FF0000);
    drain();
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 10) begin
        send_idle = 66; recv_idle = 27;
      end else if (ph == 20) begin
        send_idle = 0; recv_idle = 0;
      end
      random_phase(60);
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
